[rtl/source_text_lexer_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the source text lexer core.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_LEXER_CORE_MACROS_SVH
`define SOURCE_TEXT_LEXER_CORE_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define STL_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define STL_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

[rtl/stl_pkg.sv]
// ----------------------------------------------------------------------------
// stl_pkg
// Token kinds, lexer modes, character codes and helper functions shared by
// the source text lexer core and its step logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

    localparam int MAX_RES = 3;

    // Token kinds.
    localparam logic [5:0] K_ARROW    = 6'd0;
    localparam logic [5:0] K_DOTDOT   = 6'd1;
    localparam logic [5:0] K_INC      = 6'd2;
    localparam logic [5:0] K_DEC      = 6'd3;
    localparam logic [5:0] K_ADDEQ    = 6'd4;
    localparam logic [5:0] K_SUBEQ    = 6'd5;
    localparam logic [5:0] K_MULEQ    = 6'd6;
    localparam logic [5:0] K_DIVEQ    = 6'd7;
    localparam logic [5:0] K_SHR      = 6'd8;
    localparam logic [5:0] K_SHL      = 6'd9;
    localparam logic [5:0] K_LE       = 6'd10;
    localparam logic [5:0] K_GE       = 6'd11;
    localparam logic [5:0] K_EQEQ     = 6'd12;
    localparam logic [5:0] K_NE       = 6'd13;
    localparam logic [5:0] K_FATARROW = 6'd14;
    localparam logic [5:0] K_COLEQ    = 6'd15;
    localparam logic [5:0] K_ADD      = 6'd16;
    localparam logic [5:0] K_SUB      = 6'd17;
    localparam logic [5:0] K_STAR     = 6'd18;
    localparam logic [5:0] K_SLASH    = 6'd19;
    localparam logic [5:0] K_PERCENT  = 6'd20;
    localparam logic [5:0] K_LESS     = 6'd21;
    localparam logic [5:0] K_GREATER  = 6'd22;
    localparam logic [5:0] K_PERIOD   = 6'd23;
    localparam logic [5:0] K_EXCL     = 6'd24;
    localparam logic [5:0] K_QMARK    = 6'd25;
    localparam logic [5:0] K_COLN     = 6'd26;
    localparam logic [5:0] K_SEMI     = 6'd27;
    localparam logic [5:0] K_COMMA    = 6'd28;
    localparam logic [5:0] K_LPAR     = 6'd29;
    localparam logic [5:0] K_RPAR     = 6'd30;
    localparam logic [5:0] K_LCUR     = 6'd31;
    localparam logic [5:0] K_RCUR     = 6'd32;
    localparam logic [5:0] K_LSQ      = 6'd33;
    localparam logic [5:0] K_RSQ      = 6'd34;
    localparam logic [5:0] K_FLT      = 6'd35;
    localparam logic [5:0] K_INTL     = 6'd36;
    localparam logic [5:0] K_STR      = 6'd37;
    localparam logic [5:0] K_RAW      = 6'd38;
    localparam logic [5:0] K_IDENT    = 6'd39;

    // Error codes.
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_STR   = 2'd1;
    localparam logic [1:0] ERR_RAW   = 2'd2;
    localparam logic [1:0] ERR_BLOCK = 2'd3;

    // Item actions.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LCUR   = 8'h7B;
    localparam logic [7:0] CH_RCUR   = 8'h7D;

    typedef enum logic [4:0] {
        MODE_IDLE, MODE_DOT, MODE_PLUS, MODE_MINUS, MODE_STAR, MODE_SLASH,
        MODE_LT, MODE_GT, MODE_EQ, MODE_BANG, MODE_COLON, MODE_LINE,
        MODE_BLOCK, MODE_BLOCKSTAR, MODE_STRQ, MODE_RAWQ, MODE_INT,
        MODE_INTDOT, MODE_FLT, MODE_IDENT
    } t_mode;

    typedef struct packed {
        logic [5:0] kind;
        logic [7:0] text;
        logic       has_byte;
        logic       token_end;
        logic [1:0] err;
        logic       last;
    } t_res;

    typedef struct packed {
        logic       ok;
        logic [5:0] kind;
    } t_opt_kind;

    typedef struct packed {
        t_mode mode;
        logic  emit;
        t_res  res;
    } t_fresh;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic t_res mk_tok(input logic [5:0] kind);
        t_res r;
        r = '0;
        r.kind = kind;
        r.token_end = 1'b1;
        return r;
    endfunction

    function automatic t_res mk_chr(input logic [5:0] kind, input logic [7:0] c);
        t_res r;
        r = '0;
        r.kind = kind;
        r.text = c;
        r.has_byte = 1'b1;
        return r;
    endfunction

    function automatic t_res mk_err(input logic [1:0] code);
        t_res r;
        r = '0;
        r.err = code;
        return r;
    endfunction

    // Two-character operator formed by a pending first character and c.
    function automatic t_opt_kind pair_kind(input t_mode m, input logic [7:0] c);
        t_opt_kind k;
        k = '0;
        case (m)
            MODE_DOT: begin
                if (c == CH_DOT) k = '{1'b1, K_DOTDOT};
            end
            MODE_PLUS: begin
                if (c == CH_PLUS) k = '{1'b1, K_INC};
                else if (c == CH_EQ) k = '{1'b1, K_ADDEQ};
            end
            MODE_MINUS: begin
                if (c == CH_GT) k = '{1'b1, K_ARROW};
                else if (c == CH_MINUS) k = '{1'b1, K_DEC};
                else if (c == CH_EQ) k = '{1'b1, K_SUBEQ};
            end
            MODE_STAR: begin
                if (c == CH_EQ) k = '{1'b1, K_MULEQ};
            end
            MODE_LT: begin
                if (c == CH_LT) k = '{1'b1, K_SHL};
                else if (c == CH_EQ) k = '{1'b1, K_LE};
            end
            MODE_GT: begin
                if (c == CH_GT) k = '{1'b1, K_SHR};
                else if (c == CH_EQ) k = '{1'b1, K_GE};
            end
            MODE_EQ: begin
                if (c == CH_EQ) k = '{1'b1, K_EQEQ};
                else if (c == CH_GT) k = '{1'b1, K_FATARROW};
            end
            MODE_BANG: begin
                if (c == CH_EQ) k = '{1'b1, K_NE};
            end
            MODE_COLON: begin
                if (c == CH_EQ) k = '{1'b1, K_COLEQ};
            end
            default: k = '0;
        endcase
        return k;
    endfunction

    // Token for a pending first character that stands alone.
    function automatic t_opt_kind lone_kind(input t_mode m);
        t_opt_kind k;
        k = '0;
        case (m)
            MODE_DOT:   k = '{1'b1, K_PERIOD};
            MODE_PLUS:  k = '{1'b1, K_ADD};
            MODE_MINUS: k = '{1'b1, K_SUB};
            MODE_STAR:  k = '{1'b1, K_STAR};
            MODE_SLASH: k = '{1'b1, K_SLASH};
            MODE_LT:    k = '{1'b1, K_LESS};
            MODE_GT:    k = '{1'b1, K_GREATER};
            MODE_BANG:  k = '{1'b1, K_EXCL};
            MODE_COLON: k = '{1'b1, K_COLN};
            default:    k = '0;
        endcase
        return k;
    endfunction

    // Lexing of a byte that starts from the idle mode.
    function automatic t_fresh fresh(input logic [7:0] c);
        t_fresh f;
        f.mode = MODE_IDLE;
        f.emit = 1'b0;
        f.res  = '0;
        if (!is_space(c)) begin
            case (c)
                CH_DOT:    f.mode = MODE_DOT;
                CH_PLUS:   f.mode = MODE_PLUS;
                CH_MINUS:  f.mode = MODE_MINUS;
                CH_STAR:   f.mode = MODE_STAR;
                CH_SLASH:  f.mode = MODE_SLASH;
                CH_LT:     f.mode = MODE_LT;
                CH_GT:     f.mode = MODE_GT;
                CH_EQ:     f.mode = MODE_EQ;
                CH_BANG:   f.mode = MODE_BANG;
                CH_COLON:  f.mode = MODE_COLON;
                CH_DQUOTE: f.mode = MODE_STRQ;
                CH_SQUOTE: f.mode = MODE_RAWQ;
                CH_PCT:    begin f.emit = 1'b1; f.res = mk_tok(K_PERCENT); end
                CH_QMARK:  begin f.emit = 1'b1; f.res = mk_tok(K_QMARK);   end
                CH_SEMI:   begin f.emit = 1'b1; f.res = mk_tok(K_SEMI);    end
                CH_COMMA:  begin f.emit = 1'b1; f.res = mk_tok(K_COMMA);   end
                CH_LPAR:   begin f.emit = 1'b1; f.res = mk_tok(K_LPAR);    end
                CH_RPAR:   begin f.emit = 1'b1; f.res = mk_tok(K_RPAR);    end
                CH_LCUR:   begin f.emit = 1'b1; f.res = mk_tok(K_LCUR);    end
                CH_RCUR:   begin f.emit = 1'b1; f.res = mk_tok(K_RCUR);    end
                CH_LSQ:    begin f.emit = 1'b1; f.res = mk_tok(K_LSQ);     end
                CH_RSQ:    begin f.emit = 1'b1; f.res = mk_tok(K_RSQ);     end
                default: begin
                    if (is_digit(c)) begin
                        f.emit = 1'b1;
                        f.res  = mk_chr(K_INTL, c);
                        f.mode = MODE_INT;
                    end else if (is_alpha(c)) begin
                        f.emit = 1'b1;
                        f.res  = mk_chr(K_IDENT, c);
                        f.mode = MODE_IDENT;
                    end
                end
            endcase
        end
        return f;
    endfunction

endpackage

`default_nettype wire

[rtl/stl_step.sv]
// ----------------------------------------------------------------------------
// stl_step
// Combinational lexer step: from the current mode and one item, produces up
// to three results and the next mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stl_step (
    input  var stl_pkg::t_mode       i_mode,
    input  wire logic                i_action,
    input  wire logic [7:0]          i_byte,
    output stl_pkg::t_mode           o_mode,
    output stl_pkg::t_res [2:0]      o_res,
    output logic [1:0]               o_count
);

    stl_pkg::t_fresh    fr;
    stl_pkg::t_opt_kind pk;
    stl_pkg::t_opt_kind lk;
    stl_pkg::t_mode     mode;
    stl_pkg::t_res [2:0] res;
    logic [1:0]         cnt;

    assign fr = stl_pkg::fresh(i_byte);
    assign pk = stl_pkg::pair_kind(i_mode, i_byte);
    assign lk = stl_pkg::lone_kind(i_mode);

    always_comb begin
        mode = i_mode;
        res  = '0;
        cnt  = 2'd0;
        if (i_action == stl_pkg::ACT_END) begin
            mode = stl_pkg::MODE_IDLE;
            case (i_mode)
                stl_pkg::MODE_INT: begin
                    res[0] = stl_pkg::mk_tok(stl_pkg::K_INTL);
                    cnt = 2'd1;
                end
                stl_pkg::MODE_INTDOT: begin
                    res[0] = stl_pkg::mk_chr(stl_pkg::K_FLT, stl_pkg::CH_DOT);
                    res[1] = stl_pkg::mk_tok(stl_pkg::K_FLT);
                    cnt = 2'd2;
                end
                stl_pkg::MODE_FLT: begin
                    res[0] = stl_pkg::mk_tok(stl_pkg::K_FLT);
                    cnt = 2'd1;
                end
                stl_pkg::MODE_IDENT: begin
                    res[0] = stl_pkg::mk_tok(stl_pkg::K_IDENT);
                    cnt = 2'd1;
                end
                stl_pkg::MODE_STRQ: begin
                    res[0] = stl_pkg::mk_err(stl_pkg::ERR_STR);
                    cnt = 2'd1;
                end
                stl_pkg::MODE_RAWQ: begin
                    res[0] = stl_pkg::mk_err(stl_pkg::ERR_RAW);
                    cnt = 2'd1;
                end
                stl_pkg::MODE_BLOCK, stl_pkg::MODE_BLOCKSTAR: begin
                    res[0] = stl_pkg::mk_err(stl_pkg::ERR_BLOCK);
                    cnt = 2'd1;
                end
                default: begin
                    if (lk.ok) begin
                        res[0] = stl_pkg::mk_tok(lk.kind);
                        cnt = 2'd1;
                    end
                end
            endcase
        end else begin
            case (i_mode)
                stl_pkg::MODE_DOT, stl_pkg::MODE_PLUS, stl_pkg::MODE_MINUS,
                stl_pkg::MODE_STAR, stl_pkg::MODE_LT, stl_pkg::MODE_GT,
                stl_pkg::MODE_EQ, stl_pkg::MODE_BANG, stl_pkg::MODE_COLON: begin
                    if (pk.ok) begin
                        res[0] = stl_pkg::mk_tok(pk.kind);
                        cnt = 2'd1;
                        mode = stl_pkg::MODE_IDLE;
                    end else begin
                        // A lone '=' has no token of its own.
                        if (lk.ok) begin
                            res[cnt] = stl_pkg::mk_tok(lk.kind);
                            cnt = cnt + 2'd1;
                        end
                        mode = fr.mode;
                        if (fr.emit) begin
                            res[cnt] = fr.res;
                            cnt = cnt + 2'd1;
                        end
                    end
                end
                stl_pkg::MODE_SLASH: begin
                    if (i_byte == stl_pkg::CH_SLASH) begin
                        mode = stl_pkg::MODE_LINE;
                    end else if (i_byte == stl_pkg::CH_STAR) begin
                        mode = stl_pkg::MODE_BLOCK;
                    end else if (i_byte == stl_pkg::CH_EQ) begin
                        res[0] = stl_pkg::mk_tok(stl_pkg::K_DIVEQ);
                        cnt = 2'd1;
                        mode = stl_pkg::MODE_IDLE;
                    end else begin
                        res[0] = stl_pkg::mk_tok(stl_pkg::K_SLASH);
                        cnt = 2'd1;
                        mode = fr.mode;
                        if (fr.emit) begin
                            res[1] = fr.res;
                            cnt = 2'd2;
                        end
                    end
                end
                stl_pkg::MODE_LINE: begin
                    if (i_byte == stl_pkg::CH_NL) mode = stl_pkg::MODE_IDLE;
                end
                stl_pkg::MODE_BLOCK: begin
                    if (i_byte == stl_pkg::CH_STAR) mode = stl_pkg::MODE_BLOCKSTAR;
                end
                stl_pkg::MODE_BLOCKSTAR: begin
                    if (i_byte == stl_pkg::CH_SLASH) begin
                        mode = stl_pkg::MODE_IDLE;
                    end else if (i_byte != stl_pkg::CH_STAR) begin
                        mode = stl_pkg::MODE_BLOCK;
                    end
                end
                stl_pkg::MODE_STRQ: begin
                    cnt = 2'd1;
                    if (i_byte == stl_pkg::CH_DQUOTE) begin
                        res[0] = stl_pkg::mk_tok(stl_pkg::K_STR);
                        mode = stl_pkg::MODE_IDLE;
                    end else begin
                        res[0] = stl_pkg::mk_chr(stl_pkg::K_STR, i_byte);
                    end
                end
                stl_pkg::MODE_RAWQ: begin
                    cnt = 2'd1;
                    if (i_byte == stl_pkg::CH_SQUOTE) begin
                        res[0] = stl_pkg::mk_tok(stl_pkg::K_RAW);
                        mode = stl_pkg::MODE_IDLE;
                    end else begin
                        res[0] = stl_pkg::mk_chr(stl_pkg::K_RAW, i_byte);
                    end
                end
                stl_pkg::MODE_INT: begin
                    if (stl_pkg::is_digit(i_byte)) begin
                        res[0] = stl_pkg::mk_chr(stl_pkg::K_INTL, i_byte);
                        cnt = 2'd1;
                    end else if (i_byte == stl_pkg::CH_DOT) begin
                        mode = stl_pkg::MODE_INTDOT;
                    end else begin
                        res[0] = stl_pkg::mk_tok(stl_pkg::K_INTL);
                        cnt = 2'd1;
                        mode = fr.mode;
                        if (fr.emit) begin
                            res[1] = fr.res;
                            cnt = 2'd2;
                        end
                    end
                end
                stl_pkg::MODE_INTDOT: begin
                    if (i_byte == stl_pkg::CH_DOT) begin
                        res[0] = stl_pkg::mk_tok(stl_pkg::K_INTL);
                        res[1] = stl_pkg::mk_tok(stl_pkg::K_DOTDOT);
                        cnt = 2'd2;
                        mode = stl_pkg::MODE_IDLE;
                    end else if (stl_pkg::is_digit(i_byte)) begin
                        res[0] = stl_pkg::mk_chr(stl_pkg::K_FLT, stl_pkg::CH_DOT);
                        res[1] = stl_pkg::mk_chr(stl_pkg::K_FLT, i_byte);
                        cnt = 2'd2;
                        mode = stl_pkg::MODE_FLT;
                    end else begin
                        res[0] = stl_pkg::mk_chr(stl_pkg::K_FLT, stl_pkg::CH_DOT);
                        res[1] = stl_pkg::mk_tok(stl_pkg::K_FLT);
                        cnt = 2'd2;
                        mode = fr.mode;
                        if (fr.emit) begin
                            res[2] = fr.res;
                            cnt = 2'd3;
                        end
                    end
                end
                stl_pkg::MODE_FLT: begin
                    if (stl_pkg::is_digit(i_byte)) begin
                        res[0] = stl_pkg::mk_chr(stl_pkg::K_FLT, i_byte);
                        cnt = 2'd1;
                    end else begin
                        res[0] = stl_pkg::mk_tok(stl_pkg::K_FLT);
                        cnt = 2'd1;
                        mode = fr.mode;
                        if (fr.emit) begin
                            res[1] = fr.res;
                            cnt = 2'd2;
                        end
                    end
                end
                stl_pkg::MODE_IDENT: begin
                    if (stl_pkg::is_alpha(i_byte) || stl_pkg::is_digit(i_byte)) begin
                        res[0] = stl_pkg::mk_chr(stl_pkg::K_IDENT, i_byte);
                        cnt = 2'd1;
                    end else begin
                        res[0] = stl_pkg::mk_tok(stl_pkg::K_IDENT);
                        cnt = 2'd1;
                        mode = fr.mode;
                        if (fr.emit) begin
                            res[1] = fr.res;
                            cnt = 2'd2;
                        end
                    end
                end
                default: begin
                    mode = fr.mode;
                    if (fr.emit) begin
                        res[0] = fr.res;
                        cnt = 2'd1;
                    end
                end
            endcase
        end
        if (cnt != 2'd0) res[cnt - 2'd1].last = 1'b1;
    end

    assign o_mode  = mode;
    assign o_res   = res;
    assign o_count = cnt;

endmodule

`default_nettype wire

[rtl/source_text_lexer_core.sv]
// ----------------------------------------------------------------------------
// source_text_lexer_core
// Streaming lexer: source bytes in, operator tokens and streamed token text
// out, with an end-of-text request that flushes and reports unclosed text.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+-------------------------------------
//  in      | i_in_valid / o_in_ready   | i_action, i_source_byte
//  out     | o_out_valid / i_out_ready | o_token_kind, o_text_byte,
//          |                           | o_has_byte, o_token_end,
//          |                           | o_error_code, o_last_of_run
//
//  An accepted request sits in the input register until the result buffer
//  can take it, then the step logic turns it into zero to three results in
//  the result buffer. The result buffer drains one result per cycle while
//  the output is ready. A new request is taken every cycle as long as the
//  buffer keeps up.
//  Reset (synchronous, active low) returns the lexer mode to idle and
//  empties both the input register and the result buffer.
//  A stall on the output holds the buffer; the input register still holds
//  one further request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module source_text_lexer_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_action,
    input  wire logic [7:0] i_source_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [5:0]      o_token_kind,
    output logic [7:0]      o_text_byte,
    output logic            o_has_byte,
    output logic            o_token_end,
    output logic [1:0]      o_error_code,
    output logic            o_last_of_run
);

`include "source_text_lexer_core_macros.svh"

    // Input register.
    logic                r_in_valid;
    logic                n_in_valid;
    logic                r_in_action;
    logic [7:0]          r_in_byte;

    // Lexer state and result buffer.
    stl_pkg::t_mode      r_mode;
    stl_pkg::t_mode      n_mode;
    stl_pkg::t_res [2:0] r_res;
    logic [1:0]          r_cnt;
    logic [1:0]          n_cnt;
    logic [1:0]          r_head;
    logic [1:0]          n_head;

    stl_pkg::t_mode      step_mode;
    stl_pkg::t_res [2:0] step_res;
    logic [1:0]          step_cnt;

    logic                in_fire;
    logic                out_fire;
    logic                consume;
    stl_pkg::t_res       cur;

    stl_step u_step (
        .i_mode   (r_mode),
        .i_action (r_in_action),
        .i_byte   (r_in_byte),
        .o_mode   (step_mode),
        .o_res    (step_res),
        .o_count  (step_cnt)
    );

    assign out_fire = o_out_valid && i_out_ready;

    // The held request moves into the buffer once the buffer is empty or
    // is handing over its last result in this cycle.
    assign consume = r_in_valid &&
                     ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready));

    assign o_in_ready = !r_in_valid || consume;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (consume) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_head = r_head;
        if (consume) begin
            n_mode = step_mode;
            n_cnt  = step_cnt;
            n_head = 2'd0;
        end else if (out_fire) begin
            n_cnt  = r_cnt - 2'd1;
            n_head = r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= stl_pkg::MODE_IDLE;
            r_cnt      <= 2'd0;
            r_head     <= 2'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_mode     <= n_mode;
            r_cnt      <= n_cnt;
            r_head     <= n_head;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_action <= i_action;
            r_in_byte   <= i_source_byte;
        end
        if (consume) begin
            r_res <= step_res;
        end
    end

    assign cur           = r_res[r_head];
    assign o_out_valid   = (r_cnt != 2'd0);
    assign o_token_kind  = cur.kind;
    assign o_text_byte   = cur.text;
    assign o_has_byte    = cur.has_byte;
    assign o_token_end   = cur.token_end;
    assign o_error_code  = cur.err;
    assign o_last_of_run = cur.last;

    // The buffer never reads past its third entry.
    `STL_ASSERT_NOW(a_head_in_range, r_cnt != 2'd0, ({1'b0, r_head} + {1'b0, r_cnt}) <= 3'd3, "result buffer overrun")

    // The final result in the buffer always closes its request.
    `STL_ASSERT_NOW(a_last_flag, o_out_valid && (r_cnt == 2'd1), o_last_of_run, "last result lacks last_of_run")

    // Taking the last result with nothing to refill leaves the output idle.
    `STL_ASSERT_NEXT(a_drain_empty, out_fire && (r_cnt == 2'd1) && !consume, !o_out_valid, "output stayed valid after drain")

    // End of text always returns the lexer to idle.
    `STL_ASSERT_NEXT(a_end_idle, consume && (r_in_action == stl_pkg::ACT_END), r_mode == stl_pkg::MODE_IDLE, "mode not idle after end of text")

endmodule

`default_nettype wire
